// ----- hdl/u2cet_pkg.sv -----
// Shared constants, types and calendar helpers for the UTC to CET/CEST converter.
package u2cet_pkg;

  // Pipeline depth from input register to result register
  localparam int unsigned NUM_STAGES = 10;

  // Accepted input window, 2000-01-01 00:00:00 to 2099-12-31 23:59:59 UTC
  localparam logic [31:0] UTC_MIN = 32'd946684800;
  localparam logic [31:0] UTC_MAX = 32'd4102444799;

  // t / 86400 = (t >> 7) / 675, done as multiply by ceil(2^35 / 675)
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;

  // Days from 1970-01-01 to 2000-01-01
  localparam logic [15:0] EPOCH_2000_DAYS = 16'd10957;

  // Four-year cycle of 1461 days; quotient by multiply with ceil(2^26 / 1461)
  localparam logic [15:0] CYCLE_RECIP = 16'd45934;
  localparam logic [10:0] CYCLE_DAYS  = 11'd1461;

  // Seconds of day to hour and minute
  localparam logic [12:0] HOUR_RECIP    = 13'd4661;   // ceil(2^20 / 225)
  localparam logic [10:0] MIN_RECIP     = 11'd1093;   // ceil(2^14 / 15)
  localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;

  localparam logic [16:0] SUMMER_OFFSET = 17'd7200;
  localparam logic [16:0] WINTER_OFFSET = 17'd3600;

  // x mod 7 for 8-bit x, quotient by multiply with 293 / 2^11
  localparam logic [8:0]  MOD7_RECIP = 9'd293;

  localparam logic [11:0] BASE_YEAR = 12'd2000;

  // Day of year (from zero) of March 31 and October 31 in a common year
  localparam logic [8:0]  MAR31_DOY = 9'd89;
  localparam logic [8:0]  OCT31_DOY = 9'd303;

  // Position of a day inside the 2000-based four-year cycle
  typedef struct packed {
    logic [4:0] cycle;   // four-year cycle index since 2000
    logic [1:0] yic;     // year in cycle, zero is the leap year
    logic [8:0] doy;     // day of year from zero
    logic       leap;
  } ydate_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
  } mday_t;

  // First day of each year within the cycle
  function automatic logic [10:0] year_start(logic [1:0] yic);
    logic [10:0] s;
    unique case (yic)
      2'd0:    s = 11'd0;
      2'd1:    s = 11'd366;
      2'd2:    s = 11'd731;
      default: s = 11'd1096;
    endcase
    return s;
  endfunction

  // Weekday shift of each year start inside the cycle (year_start mod 7)
  function automatic logic [2:0] year_wday_ofs(logic [1:0] yic);
    logic [2:0] w;
    unique case (yic)
      2'd0:    w = 3'd0;
      2'd1:    w = 3'd2;
      2'd2:    w = 3'd3;
      default: w = 3'd4;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] mod7(logic [7:0] x);
    logic [16:0] p;
    logic [7:0]  r;
    p = 17'(x) * 17'(MOD7_RECIP);
    r = x - 8'({2'b00, p[16:11]} * 8'd7);
    return r[2:0];
  endfunction

  // First day of year of a month (index from zero)
  function automatic logic [8:0] month_start(logic [3:0] idx, logic leap);
    logic [8:0] s;
    unique case (idx)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (idx >= 4'd2) begin
      s = s + 9'(leap);
    end
    return s;
  endfunction

  function automatic mday_t month_day(logic [8:0] doy, logic leap);
    mday_t      md;
    logic [3:0] idx;
    logic [8:0] base;
    idx  = '0;
    base = '0;
    for (int i = 0; i < 12; i++) begin
      if (doy >= month_start(4'(i), leap)) begin
        idx  = 4'(i);
        base = month_start(4'(i), leap);
      end
    end
    md.month = idx + 4'd1;
    md.day   = 5'(doy - base) + 5'd1;
    return md;
  endfunction

endpackage

// ----- hdl/u2cet_ctl.sv -----
// Stage valid bits and advance chain for the converter pipeline.
module u2cet_ctl import u2cet_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_ready_i,
  output logic [NUM_STAGES-1:0] adv_o,
  output logic                  last_valid_o
);

  logic [NUM_STAGES-1:0] valid_q, valid_d;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv_o[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv_o[k] = !valid_q[k] || adv_o[k+1];
    end
  end

  // Shift valid bits along with the data
  always_comb begin
    valid_d = valid_q;
    if (adv_o[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv_o[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign last_valid_o = valid_q[NUM_STAGES-1];

  // Input stalls only when every stage holds a request and the output is blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_o[0] |-> ((&valid_q) && !out_ready_i))
    else $error("input stalled with a bubble in the pipeline");

  // An accepted request occupies the first stage next cycle
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && adv_o[0]) |=> valid_q[0])
    else $error("accepted request lost at the first stage");

endmodule

// ----- hdl/u2cet_split.sv -----
// Two-stage split of a day count since 2000-01-01 into cycle, year and day of year.
module u2cet_split import u2cet_pkg::*; (
  input  logic        clk_i,
  input  logic [15:0] day_i,
  input  logic [1:0]  en_i,
  output ydate_t      split_o
);

  logic [31:0] qprod;
  logic [15:0] day_q;
  logic [4:0]  cycle_q;
  logic [10:0] rem;
  logic [1:0]  yic;
  ydate_t      split_d, split_q;

  // Find the four-year cycle by reciprocal multiply
  assign qprod = 32'(day_i) * 32'(CYCLE_RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      day_q   <= day_i;
      cycle_q <= qprod[30:26];
    end
  end

  // Locate the year inside the cycle and the day inside the year
  always_comb begin
    rem = 11'(day_q - 16'(cycle_q) * 16'(CYCLE_DAYS));
    priority if (rem < 11'd366) begin
      yic = 2'd0;
    end else if (rem < 11'd731) begin
      yic = 2'd1;
    end else if (rem < 11'd1096) begin
      yic = 2'd2;
    end else begin
      yic = 2'd3;
    end
    split_d.cycle = cycle_q;
    split_d.yic   = yic;
    split_d.doy   = 9'(rem - year_start(yic));
    split_d.leap  = (yic == 2'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      split_q <= split_d;
    end
  end

  assign split_o = split_q;

endmodule

// ----- hdl/utc_to_central_europe_local_time_top.sv -----
// Top level: UTC Unix seconds to Central European local date and time.
//
// Usage:
//   Input channel carries one UTC Unix time (utc_seconds_i) per request with
//   in_valid_i / in_ready_o. Values outside 2000-01-01 .. 2099-12-31 UTC are
//   clamped to that window. The output channel returns local year, month,
//   day, hour and minute plus the summer_time_o flag with out_valid_o /
//   out_ready_i, one result per request, in order.
//   Throughput: one request per cycle, sustained while the receiver keeps
//   out_ready_i high. The pipeline has ten register stages: input register,
//   day division by reciprocal multiply, second of day and rebase to 2000,
//   two stages of four-year-cycle split for the UTC date, the summer-time
//   decision, the offset add, two stages of split for the local date, and
//   the result register.
//   Reset clears all stage valid bits; no result is pending afterwards.
//   When the receiver stalls, the result holds on the output and the earlier
//   stages keep filling their bubbles; in_ready_o drops only once all ten
//   stages hold a request.
module utc_to_central_europe_local_time_top import u2cet_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] utc_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] local_year_o,
  output logic [3:0]  local_month_o,
  output logic [4:0]  local_day_o,
  output logic [4:0]  local_hour_o,
  output logic [5:0]  local_minute_o,
  output logic        summer_time_o
);

  logic [NUM_STAGES-1:0] adv;

  logic [31:0] t0_q, t0_d;
  logic [31:0] t1_q;
  logic [15:0] day1_q;
  logic [50:0] day_prod;
  logic [31:0] day_secs;
  logic [16:0] sod2_q, sod3_q, sod4_q, sod5_q;
  logic [15:0] d2_q, d3_q, d4_q, d5_q;
  ydate_t      utc_date, loc_date;
  logic [7:0]  wd_base;
  logic [2:0]  mar_wd, oct_wd;
  logic [8:0]  start_doy, end_doy;
  logic        after_start, before_end, summer;
  logic        summer5_q, summer6_q, summer7_q, summer8_q;
  logic [17:0] lsum;
  logic        carry;
  logic [16:0] lsod6_q, lsod7_q;
  logic [15:0] ld6_q;
  logic [25:0] hour_prod;
  logic [4:0]  hour7_q, hour8_q;
  logic [11:0] mh8_q;
  logic [20:0] min_prod;
  mday_t       md;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  mday_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic        summer_q;

  u2cet_ctl u_ctl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .out_ready_i  (out_ready_i),
    .adv_o        (adv),
    .last_valid_o (out_valid_o)
  );

  assign in_ready_o = adv[0];

  // Clamp the request into the supported window
  always_comb begin
    priority if (utc_seconds_i < UTC_MIN) begin
      t0_d = UTC_MIN;
    end else if (utc_seconds_i > UTC_MAX) begin
      t0_d = UTC_MAX;
    end else begin
      t0_d = utc_seconds_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      t0_q <= t0_d;
    end
  end

  // Divide by seconds per day
  assign day_prod = 51'(t0_q[31:7]) * 51'(DAY_RECIP);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      t1_q   <= t0_q;
      day1_q <= day_prod[50:35];
    end
  end

  // Take the second of day and rebase days to 2000-01-01
  assign day_secs = 32'(33'(day1_q) * 33'(SEC_PER_DAY));

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      sod2_q <= 17'(t1_q - day_secs);
      d2_q   <= day1_q - EPOCH_2000_DAYS;
    end
  end

  // Split the UTC day to find its year
  u2cet_split u_utc_split (
    .clk_i   (clk_i),
    .day_i   (d2_q),
    .en_i    (adv[4:3]),
    .split_o (utc_date)
  );

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      sod3_q <= sod2_q;
      d3_q   <= d2_q;
    end
    if (adv[4]) begin
      sod4_q <= sod3_q;
      d4_q   <= d3_q;
    end
  end

  // Decide summer time from the last Sundays of March and October
  always_comb begin
    wd_base   = 8'({3'b000, utc_date.cycle} * 8'd5) + 8'(year_wday_ofs(utc_date.yic))
              + 8'(utc_date.leap);
    mar_wd    = mod7(wd_base + 8'd11);
    oct_wd    = mod7(wd_base + 8'd8);
    start_doy = MAR31_DOY + 9'(utc_date.leap) - 9'(mar_wd);
    end_doy   = OCT31_DOY + 9'(utc_date.leap) - 9'(oct_wd);
    after_start = (utc_date.doy > start_doy)
               || ((utc_date.doy == start_doy) && (sod4_q >= 17'(SEC_PER_HOUR)));
    before_end  = (utc_date.doy < end_doy)
               || ((utc_date.doy == end_doy) && (sod4_q < 17'(SEC_PER_HOUR)));
    summer      = after_start && before_end;
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      summer5_q <= summer;
      sod5_q    <= sod4_q;
      d5_q      <= d4_q;
    end
  end

  // Add the offset and carry into the next day
  always_comb begin
    lsum  = 18'(sod5_q) + 18'(summer5_q ? SUMMER_OFFSET : WINTER_OFFSET);
    carry = (lsum >= 18'(SEC_PER_DAY));
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      lsod6_q   <= carry ? 17'(lsum - 18'(SEC_PER_DAY)) : 17'(lsum);
      ld6_q     <= d5_q + 16'(carry);
      summer6_q <= summer5_q;
    end
  end

  // Split the local day; derive hour alongside
  u2cet_split u_loc_split (
    .clk_i   (clk_i),
    .day_i   (ld6_q),
    .en_i    (adv[8:7]),
    .split_o (loc_date)
  );

  assign hour_prod = 26'(lsod6_q[16:4]) * 26'(HOUR_RECIP);

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      hour7_q   <= hour_prod[24:20];
      lsod7_q   <= lsod6_q;
      summer7_q <= summer6_q;
    end
    if (adv[8]) begin
      mh8_q     <= 12'(lsod7_q - 17'(hour7_q) * 17'(SEC_PER_HOUR));
      hour8_q   <= hour7_q;
      summer8_q <= summer7_q;
    end
  end

  // Form month, day, minute and year for the result register
  assign min_prod = 21'(mh8_q[11:2]) * 21'(MIN_RECIP);
  assign md       = month_day(loc_date.doy, loc_date.leap);

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      year_q   <= BASE_YEAR + 12'({loc_date.cycle, 2'b00}) + 12'(loc_date.yic);
      month_q  <= md.month;
      mday_q   <= md.day;
      hour_q   <= hour8_q;
      minute_q <= min_prod[19:14];
      summer_q <= summer8_q;
    end
  end

  assign local_year_o   = year_q;
  assign local_month_o  = month_q;
  assign local_day_o    = mday_q;
  assign local_hour_o   = hour_q;
  assign local_minute_o = minute_q;
  assign summer_time_o  = summer_q;

  a_fields_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (local_month_o >= 4'd1 && local_month_o <= 4'd12
                     && local_day_o >= 5'd1 && local_hour_o <= 5'd23
                     && local_minute_o <= 6'd59))
    else $error("local time field out of range");

  a_summer_months: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && summer_time_o) |-> (local_month_o >= 4'd3 && local_month_o <= 4'd10))
    else $error("summer time flagged outside March to October");

  a_year_rollover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && local_year_o == 12'd2100)
      |-> (local_month_o == 4'd1 && local_day_o == 5'd1 && !summer_time_o))
    else $error("year 2100 beyond January 1");

endmodule
